// File: design/sdf_smooth_boolean_combine_assert.svh
// assertion macros for the smooth boolean combine block
`ifndef SDF_SMOOTH_BOOLEAN_COMBINE_ASSERT_SVH
`define SDF_SMOOTH_BOOLEAN_COMBINE_ASSERT_SVH

// same-cycle implication under asynchronous active-low reset
`define SDFSBC_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under asynchronous active-low reset
`define SDFSBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/sdfsbc_pkg.sv
// command code type for the smooth boolean combine block
package sdfsbc_pkg;

	// operation codes on the command input
	typedef enum logic [1:0] {
		CMD_UNION      = 2'd0,
		CMD_INTERSECT  = 2'd1,
		CMD_DIFFERENCE = 2'd2
	} cmd_t;

endpackage

// File: design/sdf_smooth_boolean_combine.sv
// smooth min/max combine of two signed fixed-point distances, deep pipeline
//
// Input channel: in_valid / in_stall with command, dist_a, dist_b. A transaction
// moves at a rising edge with in_valid high and in_stall low. One transaction
// can enter every cycle while in_stall is low; items are independent.
// Output channel: out_valid / out_stall with distance, from a register.
// Depth: set by the operand select and range check stages, the weight
// divider, which resolves one quotient bit per stage, then the weight, two
// multiplier stages and the final add/saturate stage.
// Throughput: one item per cycle while out_stall is low.
// Stall: when the output holds a result and out_stall is high, the whole
// pipeline freezes and in_stall goes high; nothing is dropped or repeated.
// Configuration: blend_radius is written when cfg_valid is high (cfg_ready is
// always high); write it only while no item is in flight. Zero selects the
// hard min/max.
// Reset (arst_n low): all stages empty, blend radius cleared to zero.
module sdf_smooth_boolean_combine #(
	parameter int FRAC_BITS  = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              command,
	input  logic [DATA_WIDTH-1:0]   dist_a,
	input  logic [DATA_WIDTH-1:0]   dist_b,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [DATA_WIDTH-1:0]   distance,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [DATA_WIDTH-2:0]   blend_radius
);
	import sdfsbc_pkg::*;

	localparam int W  = DATA_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int KW = DATA_WIDTH - 1;
	localparam logic [F-1:0] QHALF = F'(1) << (F - 1);
	localparam logic [F:0]   QONE  = (F + 1)'(1) << F;

	// per-item control and operands carried down the pipe
	typedef struct packed {
		logic          smooth;
		logic          neg;
		logic          epos;
		logic          dneg;
		logic [W:0]    base;
		logic [KW-1:0] mag;
	} item_t;

	// divider stage contents
	typedef struct packed {
		item_t         it;
		logic [W-1:0]  rem;
		logic [F-1:0]  quo;
	} dvst_t;

	logic          adv;
	logic [KW-1:0] radius_q;

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= '0;
		end else if (cfg_valid) begin
			radius_q <= blend_radius;
		end
	end

	// global pipeline advance: freeze only when a held result is stalled
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// stage 1: pick operands and the signed gap per command
	logic signed [W+1:0] a_x, b_x, nb_x, e_n;
	logic signed [W:0]   q_n, p_n;
	logic                neg_n;

	always_comb begin
		a_x  = {{2{dist_a[W-1]}}, dist_a};
		b_x  = {{2{dist_b[W-1]}}, dist_b};
		nb_x = -b_x;
		case (cmd_t'(command))
			CMD_UNION: begin
				q_n   = b_x[W:0];
				p_n   = a_x[W:0];
				neg_n = 1'b0;
				e_n   = b_x - a_x;
			end
			CMD_INTERSECT: begin
				q_n   = b_x[W:0];
				p_n   = a_x[W:0];
				neg_n = 1'b1;
				e_n   = a_x - b_x;
			end
			default: begin
				q_n   = a_x[W:0];
				p_n   = nb_x[W:0];
				neg_n = 1'b1;
				e_n   = nb_x - a_x;
			end
		endcase
	end

	logic                valid_s1;
	logic signed [W:0]   q_s1, p_s1;
	logic signed [W+1:0] e_s1;
	logic                neg_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			q_s1   <= q_n;
			p_s1   <= p_n;
			e_s1   <= e_n;
			neg_s1 <= neg_n;
		end
	end

	// stage 2: compare gap with the radius, form magnitude and signs
	logic signed [W+1:0] k_x, abs_e;
	logic                ge_k, le_k, epos_n;
	item_t               item_n;

	always_comb begin
		k_x    = $signed({3'b000, radius_q});
		ge_k   = e_s1 >= k_x;
		le_k   = e_s1 <= -k_x;
		abs_e  = e_s1[W+1] ? -e_s1 : e_s1;
		epos_n = !e_s1[W+1] && (e_s1 != '0);
		item_n.smooth = !ge_k && !le_k;
		item_n.neg    = neg_s1;
		item_n.epos   = epos_n;
		item_n.dneg   = neg_s1 ? e_s1[W+1] : epos_n;
		item_n.base   = ge_k ? p_s1 : q_s1;
		item_n.mag    = abs_e[KW-1:0];
	end

	logic  valid_s2;
	item_t item_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s2 <= item_n;
		end
	end

	// divider stages: one quotient bit of gap / (2 * radius) per stage
	dvst_t dv_s   [F];
	logic  dv_v_s [F];
	logic [W:0] den;

	assign den = {1'b0, radius_q, 1'b0};

	for (genvar i = 0; i < F; i++) begin : g_div
		dvst_t      src;
		logic       src_v;
		logic [W:0] r2;
		logic       take;
		dvst_t      nxt;

		if (i == 0) begin : g_first
			assign src.it  = item_s2;
			assign src.rem = {1'b0, item_s2.mag};
			assign src.quo = '0;
			assign src_v   = valid_s2;
		end else begin : g_next
			assign src   = dv_s[i-1];
			assign src_v = dv_v_s[i-1];
		end

		// restoring step
		always_comb begin
			r2       = {src.rem, 1'b0};
			take     = r2 >= den;
			nxt.it   = src.it;
			nxt.rem  = take ? W'(r2 - den) : r2[W-1:0];
			nxt.quo  = {src.quo[F-2:0], take};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[i] <= 1'b0;
			end else if (adv) begin
				dv_v_s[i] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s[i] <= nxt;
			end
		end
	end

	// stage 3: blend weight h around one half
	logic         valid_s3;
	item_t        item_s3;
	logic [F-1:0] h_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= dv_v_s[F-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s3 <= dv_s[F-1].it;
			h_s3    <= dv_s[F-1].it.epos ? QHALF + dv_s[F-1].quo
			                             : QHALF - dv_s[F-1].quo;
		end
	end

	// stage 4: gap times weight, and h * (1 - h)
	logic [F-1:0]    omh;
	logic [KW+F-1:0] t_prod;
	logic [2*F-1:0]  hh_prod;

	always_comb begin
		omh     = F'(QONE - {1'b0, h_s3});
		t_prod  = {{F{1'b0}}, item_s3.mag} * {{KW{1'b0}}, h_s3};
		hh_prod = {{F{1'b0}}, h_s3} * {{F{1'b0}}, omh};
	end

	logic          valid_s4;
	item_t         item_s4;
	logic [KW-1:0] t_s4;
	logic [F-1:0]  hh_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s4 <= item_s3;
			t_s4    <= t_prod[KW+F-1:F];
			hh_s4   <= hh_prod[2*F-1:F];
		end
	end

	// stage 5: radius times h * (1 - h), and the linear blend
	logic [KW+F-1:0]     b_prod;
	logic signed [W+1:0] base_x, t_x, part_n;

	always_comb begin
		b_prod = {{F{1'b0}}, radius_q} * {{KW{1'b0}}, hh_s4};
		base_x = {item_s4.base[W], item_s4.base};
		t_x    = $signed({3'b000, t_s4});
		if (!item_s4.smooth) begin
			part_n = base_x;
		end else if (item_s4.dneg) begin
			part_n = base_x - t_x;
		end else begin
			part_n = base_x + t_x;
		end
	end

	logic                valid_s5;
	logic signed [W+1:0] part_s5;
	logic [KW-1:0]       bump_s5;
	logic                neg_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			part_s5 <= part_n;
			bump_s5 <= item_s4.smooth ? b_prod[KW+F-1:F] : '0;
			neg_s5  <= item_s4.neg;
		end
	end

	// stage 6: apply the bump and saturate into the output register
	logic signed [W+2:0] res, bump_x;
	logic [W-1:0]        sat_n;

	always_comb begin
		bump_x = $signed({4'b0000, bump_s5});
		res    = neg_s5 ? {part_s5[W+1], part_s5} + bump_x
		                : {part_s5[W+1], part_s5} - bump_x;
		if (res[W+2:W-1] == '0 || res[W+2:W-1] == '1) begin
			sat_n = res[W-1:0];
		end else if (res[W+2]) begin
			sat_n = {1'b1, {(W-1){1'b0}}};
		end else begin
			sat_n = {1'b0, {(W-1){1'b1}}};
		end
	end

	logic         valid_s6;
	logic [W-1:0] distance_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (adv) begin
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			distance_s6 <= sat_n;
		end
	end

	assign out_valid = valid_s6;
	assign distance  = distance_s6;

endmodule

// File: design/sdfsbc_checker.sv
// port-level checker for the smooth boolean combine block, with its bind
`include "sdf_smooth_boolean_combine_assert.svh"

module sdfsbc_checker #(
	parameter int DATA_WIDTH = 32
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic [1:0]            command,
	input logic [DATA_WIDTH-1:0] dist_a,
	input logic [DATA_WIDTH-1:0] dist_b,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [DATA_WIDTH-1:0] distance,
	input logic                  cfg_valid,
	input logic                  cfg_ready,
	input logic [DATA_WIDTH-2:0] blend_radius
);
	logic       in_txn, out_txn;
	logic [7:0] flight_q;

	assign in_txn  = in_valid && !in_stall;
	assign out_txn = out_valid && !out_stall;

	// transactions accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flight_q <= '0;
		end else if (in_txn && !out_txn) begin
			flight_q <= flight_q + 8'd1;
		end else if (out_txn && !in_txn) begin
			flight_q <= flight_q - 8'd1;
		end
	end

	// input is only held back by a stalled output result
	`SDFSBC_ASSERT(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall, "input stalled without output backpressure")

	// a stalled result stays put
	`SDFSBC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(distance), "stalled result changed")

	// no result without an accepted transaction behind it
	`SDFSBC_ASSERT(a_no_phantom, clk, arst_n, out_valid, flight_q != 8'd0, "result with nothing in flight")

endmodule

bind sdf_smooth_boolean_combine sdfsbc_checker #(.DATA_WIDTH(DATA_WIDTH)) u_sdfsbc_checker (.*);
